### design/ertb_pkg.sv
package ertb_pkg;

    // Fixed-point format of the trig values
    localparam int TRIG_FRAC_BITS = 30;

    // Accumulator holds the sum of two 64-bit products without overflow
    localparam int ACC_W = 65;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Z = 3'd5;

    // Cosine 1.0, sine 0
    localparam logic [63:0] TRIG_RESET = 64'h4000_0000_0000_0000;

    // Sequencer step count
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_DONE = 4'd15;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } t_axis;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    // One multiply issued to the shared unit, with its accumulate tags
    typedef struct packed {
        logic  valid;
        t_axis src;
        t_axis trig;
        logic  use_sin;
        logic  neg;
        logic  first;
        logic  last;
        t_axis dest;
        logic  fin;
    } t_op;

    // Writeback of a finished coordinate
    typedef struct packed {
        logic  valid;
        t_axis dest;
    } t_wb;

endpackage

### design/euler_rotate_translate_bbox.sv
// Channel  | Handshake                  | Beat contents
// ---------+----------------------------+--------------------------------------------
// in       | i_in_valid / o_in_ready    | point x, y, z (Q16.16), first_point
// out      | o_out_valid / i_out_ready  | out x, y, z, box min x/y, box max x/y
// cfg      | i_cfg_we                   | i_cfg_idx, i_cfg_data (64 bits)
//
// A new point is accepted only after the last has run its 16 sequencer steps, which feed twelve
// products through one 32x32 multiplier and one 65-bit accumulator; ready rises again as
// the box update loads the output register.
// The result appears in the cycle after the last step; a point is accepted while it waits.
// A stalled output holds the sequencer on its last step until the beat is taken.
// Reset gives identity rotation, zero translation and an empty bounding box.
module euler_rotate_translate_bbox (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ertb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [63:0]                       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [31:0]                i_point_x,
    input  logic signed [31:0]                i_point_y,
    input  logic signed [31:0]                i_point_z,
    input  logic                              i_first_point,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [31:0]                o_out_x,
    output logic signed [31:0]                o_out_y,
    output logic signed [31:0]                o_out_z,
    output logic signed [31:0]                o_box_min_x,
    output logic signed [31:0]                o_box_min_y,
    output logic signed [31:0]                o_box_max_x,
    output logic signed [31:0]                o_box_max_y
);
    import ertb_pkg::*;

    logic [63:0]        r_trig_x, r_trig_y, r_trig_z;
    logic signed [31:0] r_shift_x, r_shift_y, r_shift_z;
    logic signed [31:0] r_x, r_y, r_z;
    logic               r_first;

    t_op                op;
    t_wb                wb;
    logic signed [31:0] wb_data;
    logic signed [31:0] coord;
    logic signed [31:0] trig;
    logic signed [31:0] shift;
    logic [63:0]        trig_pair;
    logic               done;
    logic               accept;

    assign accept = i_in_valid && o_in_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_x  <= TRIG_RESET;
            r_trig_y  <= TRIG_RESET;
            r_trig_z  <= TRIG_RESET;
            r_shift_x <= '0;
            r_shift_y <= '0;
            r_shift_z <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TRIG_X:  r_trig_x  <= i_cfg_data;
                CFG_TRIG_Y:  r_trig_y  <= i_cfg_data;
                CFG_TRIG_Z:  r_trig_z  <= i_cfg_data;
                CFG_SHIFT_X: r_shift_x <= i_cfg_data[31:0];
                CFG_SHIFT_Y: r_shift_y <= i_cfg_data[31:0];
                CFG_SHIFT_Z: r_shift_z <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Working coordinates: load on accept, overwrite on writeback
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x     <= i_point_x;
            r_y     <= i_point_y;
            r_z     <= i_point_z;
            r_first <= i_first_point;
        end else if (wb.valid) begin
            unique case (wb.dest)
                AX_X:    r_x <= wb_data;
                AX_Y:    r_y <= wb_data;
                AX_Z:    r_z <= wb_data;
                default: ;
            endcase
        end
    end

    // Operand selection for the shared unit
    always_comb begin
        unique case (op.src)
            AX_X:    coord = r_x;
            AX_Y:    coord = r_y;
            AX_Z:    coord = r_z;
            default: coord = r_x;
        endcase
        unique case (op.trig)
            AX_X:    trig_pair = r_trig_x;
            AX_Y:    trig_pair = r_trig_y;
            AX_Z:    trig_pair = r_trig_z;
            default: trig_pair = r_trig_x;
        endcase
        trig = op.use_sin ? trig_pair[31:0] : trig_pair[63:32];
        unique case (wb.dest)
            AX_X:    shift = r_shift_x;
            AX_Y:    shift = r_shift_y;
            AX_Z:    shift = r_shift_z;
            default: shift = r_shift_x;
        endcase
    end

    ertb_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_busy (o_out_valid && !i_out_ready),
        .o_in_ready (o_in_ready),
        .o_done     (done),
        .o_op       (op)
    );

    ertb_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (op),
        .i_coord   (coord),
        .i_trig    (trig),
        .i_shift   (shift),
        .o_wb      (wb),
        .o_wb_data (wb_data)
    );

    ertb_bbox u_bbox (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_done      (done),
        .i_first     (r_first),
        .i_x         (r_x),
        .i_y         (r_y),
        .i_z         (r_z),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_box_min_x (o_box_min_x),
        .o_box_min_y (o_box_min_y),
        .o_box_max_x (o_box_max_x),
        .o_box_max_y (o_box_max_y)
    );

endmodule

### design/ertb_mac.sv
module ertb_mac (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ertb_pkg::t_op        i_op,
    input  logic signed [31:0]   i_coord,
    input  logic signed [31:0]   i_trig,
    input  logic signed [31:0]   i_shift,
    output ertb_pkg::t_wb        o_wb,
    output logic signed [31:0]   o_wb_data
);
    import ertb_pkg::*;

    localparam logic signed [ACC_W-1:0] HALF    = 65'sd1 <<< (TRIG_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] MAX_ACC = 65'sd2147483647;
    localparam logic signed [ACC_W-1:0] MIN_ACC = -65'sd2147483648;

    t_op                      r_p_op, n_p_op;
    logic signed [63:0]       r_prod, n_prod;
    t_op                      r_a_op, n_a_op;
    logic signed [ACC_W-1:0]  r_acc, n_acc;

    logic signed [ACC_W-1:0]  p_ext;
    logic signed [ACC_W-1:0]  acc_base;
    logic signed [ACC_W-1:0]  q;
    logic signed [31:0]       rot;
    logic signed [32:0]       moved;

    // Multiply stage: full signed 32x32 product
    always_comb begin
        n_p_op = i_op;
        n_prod = 64'(i_coord) * 64'(i_trig);
    end

    // Accumulate stage: restart with the rounding half on the first product
    always_comb begin
        p_ext    = {r_prod[63], r_prod};
        acc_base = r_p_op.first ? HALF : r_acc;
        n_a_op   = r_p_op;
        n_acc    = r_acc;
        if (r_p_op.valid) begin
            n_acc = acc_base + (r_p_op.neg ? -p_ext : p_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_op <= '0;
            r_a_op <= '0;
        end else begin
            r_p_op <= n_p_op;
            r_a_op <= n_a_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_acc  <= n_acc;
    end

    // Finish: floor shift, saturate, then add the translation where final
    always_comb begin
        q = r_acc >>> TRIG_FRAC_BITS;
        if (q > MAX_ACC) begin
            rot = 32'sh7fff_ffff;
        end else if (q < MIN_ACC) begin
            rot = -32'sh8000_0000;
        end else begin
            rot = q[31:0];
        end
        moved = {rot[31], rot} + {i_shift[31], i_shift};
        if (!r_a_op.fin) begin
            o_wb_data = rot;
        end else if (moved[32] != moved[31]) begin
            o_wb_data = moved[32] ? -32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            o_wb_data = moved[31:0];
        end
        o_wb.valid = r_a_op.valid && r_a_op.last;
        o_wb.dest  = r_a_op.dest;
    end

endmodule

### design/ertb_seq.sv
module ertb_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_busy,
    output logic           o_in_ready,
    output logic           o_done,
    output ertb_pkg::t_op  o_op
);
    import ertb_pkg::*;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;

    function automatic t_op mk(input t_axis src, input t_axis trig, input logic use_sin,
                               input logic neg, input logic first, input logic last,
                               input t_axis dest, input logic fin);
        t_op op;
        op.valid   = 1'b1;
        op.src     = src;
        op.trig    = trig;
        op.use_sin = use_sin;
        op.neg     = neg;
        op.first   = first;
        op.last    = last;
        op.dest    = dest;
        op.fin     = fin;
        return op;
    endfunction

    // Next state and step
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (i_in_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_step != STEP_DONE) begin
                    n_step = r_step + 1'b1;
                end else if (!i_out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Schedule of the twelve products; the bubble waits for the new Z
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        o_done     = (r_state == ST_RUN) && (r_step == STEP_DONE) && !i_out_busy;
        o_op       = '0;
        if (r_state == ST_RUN) begin
            unique case (r_step)
                4'd0:  o_op = mk(AX_Y, AX_X, 1'b0, 1'b0, 1'b1, 1'b0, AX_Y, 1'b0);
                4'd1:  o_op = mk(AX_Z, AX_X, 1'b1, 1'b1, 1'b0, 1'b1, AX_Y, 1'b0);
                4'd2:  o_op = mk(AX_Y, AX_X, 1'b1, 1'b0, 1'b1, 1'b0, AX_Z, 1'b0);
                4'd3:  o_op = mk(AX_Z, AX_X, 1'b0, 1'b0, 1'b0, 1'b1, AX_Z, 1'b0);
                4'd4:  o_op = mk(AX_X, AX_Y, 1'b0, 1'b0, 1'b1, 1'b0, AX_X, 1'b0);
                4'd6:  o_op = mk(AX_Z, AX_Y, 1'b1, 1'b0, 1'b0, 1'b1, AX_X, 1'b0);
                4'd7:  o_op = mk(AX_X, AX_Y, 1'b1, 1'b1, 1'b1, 1'b0, AX_Z, 1'b1);
                4'd8:  o_op = mk(AX_Z, AX_Y, 1'b0, 1'b0, 1'b0, 1'b1, AX_Z, 1'b1);
                4'd9:  o_op = mk(AX_X, AX_Z, 1'b0, 1'b0, 1'b1, 1'b0, AX_X, 1'b1);
                4'd10: o_op = mk(AX_Y, AX_Z, 1'b1, 1'b1, 1'b0, 1'b1, AX_X, 1'b1);
                4'd11: o_op = mk(AX_X, AX_Z, 1'b1, 1'b0, 1'b1, 1'b0, AX_Y, 1'b1);
                4'd12: o_op = mk(AX_Y, AX_Z, 1'b0, 1'b0, 1'b0, 1'b1, AX_Y, 1'b1);
                default: o_op = '0;
            endcase
        end
    end

endmodule

### design/ertb_bbox.sv
module ertb_bbox (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_done,
    input  logic                i_first,
    input  logic signed [31:0]  i_x,
    input  logic signed [31:0]  i_y,
    input  logic signed [31:0]  i_z,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic signed [31:0]  o_out_x,
    output logic signed [31:0]  o_out_y,
    output logic signed [31:0]  o_out_z,
    output logic signed [31:0]  o_box_min_x,
    output logic signed [31:0]  o_box_min_y,
    output logic signed [31:0]  o_box_max_x,
    output logic signed [31:0]  o_box_max_y
);
    import ertb_pkg::*;

    localparam logic signed [31:0] POS_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] NEG_MAX = -32'sh8000_0000;

    logic               r_valid, n_valid;
    logic signed [31:0] r_low_x, n_low_x, r_low_y, n_low_y;
    logic signed [31:0] r_high_x, n_high_x, r_high_y, n_high_y;
    logic signed [31:0] r_out_x, r_out_y, r_out_z;

    // Restart on a first point, then widen the box to take the point in
    always_comb begin
        n_low_x  = r_low_x;
        n_low_y  = r_low_y;
        n_high_x = r_high_x;
        n_high_y = r_high_y;
        if (i_done) begin
            if (i_first || i_x < r_low_x)  n_low_x  = i_x;
            if (i_first || i_y < r_low_y)  n_low_y  = i_y;
            if (i_first || i_x > r_high_x) n_high_x = i_x;
            if (i_first || i_y > r_high_y) n_high_y = i_y;
        end
        n_valid = i_done || (r_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_low_x  <= POS_MAX;
            r_low_y  <= POS_MAX;
            r_high_x <= NEG_MAX;
            r_high_y <= NEG_MAX;
        end else begin
            r_valid  <= n_valid;
            r_low_x  <= n_low_x;
            r_low_y  <= n_low_y;
            r_high_x <= n_high_x;
            r_high_y <= n_high_y;
        end
    end

    // Hold the output beat until it is taken
    always_ff @(posedge i_clk) begin
        if (i_done) begin
            r_out_x <= i_x;
            r_out_y <= i_y;
            r_out_z <= i_z;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_out_z     = r_out_z;
    assign o_box_min_x = r_low_x;
    assign o_box_min_y = r_low_y;
    assign o_box_max_x = r_high_x;
    assign o_box_max_y = r_high_y;

endmodule

### design/ertb_check.sv
module ertb_check (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_ready,
    input  logic                o_out_valid,
    input  logic signed [31:0]  o_out_x,
    input  logic signed [31:0]  o_out_y,
    input  logic signed [31:0]  o_box_min_x,
    input  logic signed [31:0]  o_box_min_y,
    input  logic signed [31:0]  o_box_max_x,
    input  logic signed [31:0]  o_box_max_y
);

    // No result is shown straight after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // An accepted point keeps the block busy the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after accept");

    // The box shown with a valid result is never inverted
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_box_min_x <= o_box_max_x) && (o_box_min_y <= o_box_max_y))
        else $error("bounding box inverted");

    // The point shown lies inside the box shown
    a_point_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_box_min_x <= o_out_x) && (o_out_x <= o_box_max_x)
                     && (o_box_min_y <= o_out_y) && (o_out_y <= o_box_max_y))
        else $error("point outside bounding box");

endmodule

bind euler_rotate_translate_bbox ertb_check u_ertb_check (.*);

### test/tb_euler_rotate_translate_bbox.sv
`timescale 1ns / 100ps

module tb_euler_rotate_translate_bbox;

    import ertb_pkg::*;

    localparam int FRAC = 30;
    localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;
    localparam logic signed [65:0] HALF = 66'sd536870912;
    localparam logic signed [65:0] HI32 = 66'sd2147483647;
    localparam logic signed [65:0] LO32 = -66'sd2147483648;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 66;

    // Indexes past the register list, which the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               first;
    } t_point_beat;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
    } t_bbox_beat;

    typedef struct packed {
        t_point_beat pt;
        logic        typed;
        t_bbox_beat  res;
    } t_dir_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_idx = '0;
    logic [63:0]              i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic signed [31:0]       i_point_x = '0;
    logic signed [31:0]       i_point_y = '0;
    logic signed [31:0]       i_point_z = '0;
    logic                     i_first_point = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [31:0]       o_out_x;
    logic signed [31:0]       o_out_y;
    logic signed [31:0]       o_out_z;
    logic signed [31:0]       o_box_min_x;
    logic signed [31:0]       o_box_min_y;
    logic signed [31:0]       o_box_max_x;
    logic signed [31:0]       o_box_max_y;

    // Shadow of the block's registers and box state
    logic [63:0]              trig_rx, trig_ry, trig_rz;
    logic signed [31:0]       offs_x, offs_y, offs_z;
    logic signed [31:0]       box_lo_x, box_lo_y, box_hi_x, box_hi_y;

    t_bbox_beat               pending_beats[$];
    t_dir_row                 dir_table[$];
    int                       mismatch_count = 0;
    bit                       quiet = 1'b0;

    euler_rotate_translate_bbox DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .i_first_point (i_first_point),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_box_min_x   (o_box_min_x),
        .o_box_min_y   (o_box_min_y),
        .o_box_max_x   (o_box_max_x),
        .o_box_max_y   (o_box_max_y)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Give up well past the slowest legal run
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > HI32) return MAXV;
        if (v < LO32) return MINV;
        return v[31:0];
    endfunction

    function automatic longint prod(input logic signed [31:0] a, input logic signed [31:0] b);
        return longint'(a) * longint'(b);
    endfunction

    // Sum two products in 66 bits so that +2^63 survives, round, floor-shift, clamp
    function automatic logic signed [31:0] rot_stage(input longint p1, input longint p2);
        logic signed [65:0] acc;
        acc = p1;
        acc = acc + p2 + HALF;
        acc = acc >>> FRAC;
        return sat32(acc);
    endfunction

    function automatic logic signed [31:0] add_offset(input logic signed [31:0] v,
                                                      input logic signed [31:0] o);
        logic signed [65:0] acc;
        acc = v;
        acc = acc + o;
        return sat32(acc);
    endfunction

    // Rotate X, Y, Z, translate, and fold the point into the running box
    function automatic t_bbox_beat transform_point(input t_point_beat p);
        logic signed [31:0] x, y, z, c, s, nx, ny, nz;
        t_bbox_beat r;
        x = p.x;
        y = p.y;
        z = p.z;
        c = trig_rx[63:32];
        s = trig_rx[31:0];
        ny = rot_stage(prod(y, c), -prod(z, s));
        nz = rot_stage(prod(y, s), prod(z, c));
        y = ny;
        z = nz;
        c = trig_ry[63:32];
        s = trig_ry[31:0];
        nx = rot_stage(prod(x, c), prod(z, s));
        nz = rot_stage(-prod(x, s), prod(z, c));
        x = nx;
        z = nz;
        c = trig_rz[63:32];
        s = trig_rz[31:0];
        nx = rot_stage(prod(x, c), -prod(y, s));
        ny = rot_stage(prod(x, s), prod(y, c));
        x = add_offset(nx, offs_x);
        y = add_offset(ny, offs_y);
        z = add_offset(z, offs_z);
        if (p.first) begin
            box_lo_x = x;
            box_hi_x = x;
            box_lo_y = y;
            box_hi_y = y;
        end
        if (x < box_lo_x) box_lo_x = x;
        if (y < box_lo_y) box_lo_y = y;
        if (x > box_hi_x) box_hi_x = x;
        if (y > box_hi_y) box_hi_y = y;
        r.out_x = x;
        r.out_y = y;
        r.out_z = z;
        r.min_x = box_lo_x;
        r.min_y = box_lo_y;
        r.max_x = box_hi_x;
        r.max_y = box_hi_y;
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] edge_value();
        case ($urandom_range(0, 3))
            0: return MAXV;
            1: return MINV;
            2: return 32'sd0;
            default: return -32'sd1;
        endcase
    endfunction

    // Mostly printer-sized coordinates, some raw words and limits
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return edge_value();
            default: return int'($urandom_range(0, 1 << 27)) - (1 << 26);
        endcase
    endfunction

    function automatic logic [63:0] angle_trig(input int deg);
        real ang;
        int cv, sv;
        ang = deg * 3.14159265358979 / 180.0;
        cv = $rtoi($cos(ang) * 1073741824.0);
        sv = $rtoi($sin(ang) * 1073741824.0);
        return {cv[31:0], sv[31:0]};
    endfunction

    task automatic add_row(input logic signed [31:0] x, input logic signed [31:0] y,
                           input logic signed [31:0] z, input logic f,
                           input logic signed [31:0] mnx, input logic signed [31:0] mny,
                           input logic signed [31:0] mxx, input logic signed [31:0] mxy);
        t_dir_row row;
        row.pt = '{x: x, y: y, z: z, first: f};
        row.typed = 1'b1;
        // Identity transform straight after reset: the point passes through
        row.res = '{out_x: x, out_y: y, out_z: z, min_x: mnx, min_y: mny,
                    max_x: mxx, max_y: mxy};
        dir_table.insert(dir_table.size(), row);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_TRIG_X:  trig_rx = val;
            CFG_TRIG_Y:  trig_ry = val;
            CFG_TRIG_Z:  trig_rz = val;
            CFG_SHIFT_X: offs_x = val[31:0];
            CFG_SHIFT_Y: offs_y = val[31:0];
            CFG_SHIFT_Z: offs_z = val[31:0];
            default: ;
        endcase
    endtask

    // Hold the input back until every outstanding beat has been taken
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Present one point, hold it until accepted, then queue its result
    task automatic send_point(input t_point_beat p, input logic use_typed,
                              input t_bbox_beat typed_res);
        int gap;
        t_bbox_beat r;
        gap = idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_point_x     <= p.x;
        i_point_y     <= p.y;
        i_point_z     <= p.z;
        i_first_point <= p.first;
        do @(posedge i_clk); while (!o_in_ready);
        r = transform_point(p);
        if (use_typed) r = typed_res;
        pending_beats.insert(pending_beats.size(), r);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Receive side: check each beat, then decide the next stall
    initial begin
        int stall_left;
        t_bbox_beat want;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (pending_beats.size() == 0) begin
                    $error("result beat with nothing outstanding");
                    mismatch_count++;
                end else begin
                    want = pending_beats.pop_front();
                    check_field("out_x", want.out_x, o_out_x);
                    check_field("out_y", want.out_y, o_out_y);
                    check_field("out_z", want.out_z, o_out_z);
                    check_field("box_min_x", want.min_x, o_box_min_x);
                    check_field("box_min_y", want.min_y, o_box_min_y);
                    check_field("box_max_x", want.max_x, o_box_max_x);
                    check_field("box_max_y", want.max_y, o_box_max_y);
                end
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 99) < 30) stall_left = idle_len();
            end
        end
    end

    initial begin
        t_point_beat p;
        t_bbox_beat none;
        logic signed [31:0] cx, cy, cz;
        int kind;

        none = '0;
        trig_rx = TRIG_RESET;
        trig_ry = TRIG_RESET;
        trig_rz = TRIG_RESET;
        offs_x = '0;
        offs_y = '0;
        offs_z = '0;
        box_lo_x = MAXV;
        box_lo_y = MAXV;
        box_hi_x = MINV;
        box_hi_y = MINV;

        // Points walked under several settings; results typed only for the first walk
        add_row(32'sd5, -32'sd7, 32'sd9, 1'b0, 32'sd5, -32'sd7, 32'sd5, -32'sd7);
        add_row(MAXV, MINV, MAXV, 1'b0, 32'sd5, MINV, MAXV, -32'sd7);
        add_row(MINV, MAXV, MINV, 1'b0, MINV, MINV, MAXV, MAXV);
        add_row(32'sd100, 32'sd200, -32'sd300, 1'b1, 32'sd100, 32'sd200, 32'sd100, 32'sd200);
        add_row(-32'sd1, -32'sd1, -32'sd1, 1'b0, -32'sd1, -32'sd1, 32'sd100, 32'sd200);
        add_row(MINV, MINV, MINV, 1'b1, MINV, MINV, MINV, MINV);
        add_row(MAXV, MAXV, MAXV, 1'b0, MINV, MINV, MAXV, MAXV);
        add_row(32'sd0, 32'sd0, 32'sd0, 1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: identity rotation, no offset, box from its reset values
        foreach (dir_table[i]) send_point(dir_table[i].pt, 1'b1, dir_table[i].res);
        wait_idle();

        // Negative trig limits: the sum of two products reaches +2^63
        set_reg(CFG_TRIG_X, {MINV, MINV});
        set_reg(CFG_TRIG_Y, {MINV, MINV});
        set_reg(CFG_TRIG_Z, {MINV, MINV});
        set_reg(CFG_SHIFT_X, {32'h0, MAXV});
        set_reg(CFG_SHIFT_Y, {32'h0, MAXV});
        set_reg(CFG_SHIFT_Z, {32'h0, MAXV});
        foreach (dir_table[i]) send_point(dir_table[i].pt, 1'b0, none);
        wait_idle();

        // Positive and mixed trig limits, negative offsets, and writes to unused indexes
        set_reg(CFG_TRIG_X, {MAXV, MAXV});
        set_reg(CFG_TRIG_Y, {MINV, MAXV});
        set_reg(CFG_TRIG_Z, {MAXV, MINV});
        set_reg(CFG_SHIFT_X, {32'hFFFF_FFFF, MINV});
        set_reg(CFG_SHIFT_Y, {32'h0, MINV});
        set_reg(CFG_SHIFT_Z, {32'h1234_5678, MINV});
        set_reg(CFG_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF);
        set_reg(CFG_SPARE_B, 64'h0123_4567_89AB_CDEF);
        foreach (dir_table[i]) send_point(dir_table[i].pt, 1'b0, none);
        wait_idle();

        // Random phases, each under fresh settings
        for (int ph = 0; ph < PHASES; ph++) begin
            quiet = (ph == 1) || ($urandom_range(0, 3) == 0);
            kind = (ph < 4) ? ph : $urandom_range(0, 3);
            case (kind)
                0, 1: begin
                    set_reg(CFG_TRIG_X, angle_trig($urandom_range(0, 359)));
                    set_reg(CFG_TRIG_Y, angle_trig($urandom_range(0, 359)));
                    set_reg(CFG_TRIG_Z, angle_trig($urandom_range(0, 359)));
                    cx = int'($urandom_range(0, 1 << 27)) - (1 << 26);
                    cy = int'($urandom_range(0, 1 << 27)) - (1 << 26);
                    cz = int'($urandom_range(0, 1 << 27)) - (1 << 26);
                end
                2: begin
                    set_reg(CFG_TRIG_X, {$urandom, $urandom});
                    set_reg(CFG_TRIG_Y, {$urandom, $urandom});
                    set_reg(CFG_TRIG_Z, {$urandom, $urandom});
                    cx = $urandom;
                    cy = $urandom;
                    cz = $urandom;
                end
                default: begin
                    set_reg(CFG_TRIG_X, {edge_value(), edge_value()});
                    set_reg(CFG_TRIG_Y, {edge_value(), edge_value()});
                    set_reg(CFG_TRIG_Z, {edge_value(), edge_value()});
                    cx = edge_value();
                    cy = edge_value();
                    cz = edge_value();
                end
            endcase
            set_reg(CFG_SHIFT_X, {$urandom, cx});
            set_reg(CFG_SHIFT_Y, {$urandom, cy});
            set_reg(CFG_SHIFT_Z, {$urandom, cz});
            if ($urandom_range(0, 1) == 0) set_reg(CFG_SPARE_A, {$urandom, $urandom});

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Now and then drain fully before the next point
                if ($urandom_range(0, 79) == 0) wait_idle();
                p.x = rand_coord();
                p.y = rand_coord();
                p.z = rand_coord();
                p.first = (n == 0) || ($urandom_range(0, 15) == 0);
                send_point(p, 1'b0, none);
            end
            wait_idle();
        end

        quiet = 1'b0;
        i_in_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && pending_beats.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
